// ===== src/bcft_pkg.sv =====
// shared types and constants for the ball center from triangle block
package bcft_pkg;

   localparam int AXES      = 3;
   localparam int HELD      = 2;
   localparam int CW        = 32;
   localparam int EW        = 33;
   localparam int NW        = 16;
   localparam int MW        = 12;
   localparam int MANT_MAX  = 2047;
   localparam int EXPW      = 5;
   localparam int NCW       = 25;
   localparam int AAW       = 24;
   localparam int ABW       = 25;
   localparam int DW        = 50;
   localparam int SW        = 51;
   localparam int NUMW      = 64;
   localparam int MAGW      = 63;
   localparam int BIGW      = 86;
   localparam int QW        = 41;
   localparam int UW        = 42;
   localparam int DIV_REM_W = 51;
   localparam int STEP_W    = 6;
   localparam int U_STEPS   = 41;
   localparam int O_STEPS   = 32;
   localparam int RADW      = 64;
   localparam int ROOTW     = 32;
   localparam int SQRT_REMW = 36;
   localparam int SHIFTW    = 5;
   localparam int AXISW     = 2;
   localparam int SUMW      = 44;

   localparam logic [QW-1:0] QUOT_CAP = 41'h100_0000_0000;

   typedef struct packed {
      logic [AXES-1:0][CW-1:0]          p0;
      logic [AXES-1:0][EW-1:0]          a;
      logic [AXES-1:0][EW-1:0]          b;
      logic [AXES-1:0][AXES-1:0][NW-1:0] nv;
   } geom_type;

   typedef struct packed {
      logic              start;
      logic [STEP_W-1:0] steps;
   } div_req_type;

   typedef enum logic [4:0] {
      ST_IDLE,
      ST_NORM,
      ST_CROSS,
      ST_DOTS,
      ST_DSQ,
      ST_ORIENT,
      ST_SNTN,
      ST_UNUM,
      ST_USTART,
      ST_UWAIT,
      ST_UACC,
      ST_RB,
      ST_RCMP,
      ST_HWAIT,
      ST_DNORM,
      ST_SWAIT,
      ST_OMUL,
      ST_OSTART,
      ST_OWAIT,
      ST_OUT
   } back_state_type;

endpackage

// ===== src/bcft_fifo.sv =====
// two-entry job queue between the point collector and the solver
module bcft_fifo #(
   parameter int WIDTH = 8
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   output logic             full,
   input  logic             pop,
   output logic             not_empty,
   output logic [WIDTH-1:0] pop_data
);

   localparam int DEPTH = 2;

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic             wr_ptr_ff, wr_ptr_in;
   logic             rd_ptr_ff, rd_ptr_in;
   logic [1:0]       count_ff, count_in;

   always_comb begin
      full      = (count_ff == 2'(DEPTH));
      not_empty = (count_ff != 2'd0);
      pop_data  = mem_ff[rd_ptr_ff];
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + 2'(push) - 2'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// ===== src/bcft_front.sv =====
// point collector: holds two points and forms a triangle job on the third
module bcft_front #(
   parameter int ID_WIDTH = 16
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  logic signed [31:0]        req_point_x,
   input  logic signed [31:0]        req_point_y,
   input  logic signed [31:0]        req_point_z,
   input  logic signed [15:0]        req_normal_x,
   input  logic signed [15:0]        req_normal_y,
   input  logic signed [15:0]        req_normal_z,
   input  logic [15:0]               req_point_id,
   output logic                      job_push,
   output bcft_pkg::geom_type        job_geom,
   output logic [3*ID_WIDTH-1:0]     job_ids,
   input  logic                      job_full
);

   logic [1:0]                  slot_ff, slot_in;
   logic [bcft_pkg::CW-1:0]     p_ff  [bcft_pkg::HELD][bcft_pkg::AXES];
   logic [bcft_pkg::NW-1:0]     nv_ff [bcft_pkg::HELD][bcft_pkg::AXES];
   logic [ID_WIDTH-1:0]         id_ff [bcft_pkg::HELD];
   logic                        accept;
   logic                        third;
   logic [bcft_pkg::CW-1:0]     p_cur [bcft_pkg::AXES];
   logic [bcft_pkg::NW-1:0]     nv_cur [bcft_pkg::AXES];
   logic [ID_WIDTH-1:0]         id_cur;

   always_comb begin
      p_cur[0]  = req_point_x;
      p_cur[1]  = req_point_y;
      p_cur[2]  = req_point_z;
      nv_cur[0] = req_normal_x;
      nv_cur[1] = req_normal_y;
      nv_cur[2] = req_normal_z;
      id_cur    = ID_WIDTH'(req_point_id);
      third     = (slot_ff == 2'(bcft_pkg::HELD));
      req_ready = !third || !job_full;
      accept    = req_valid && req_ready;
      job_push  = accept && third;
      slot_in   = slot_ff;
      if (accept) begin
         slot_in = third ? 2'd0 : slot_ff + 2'd1;
      end
      // edge vectors are exact 33-bit differences
      for (int c = 0; c < bcft_pkg::AXES; c++) begin
         job_geom.p0[c]    = p_ff[0][c];
         job_geom.a[c]     = {p_ff[1][c][bcft_pkg::CW-1], p_ff[1][c]}
                           - {p_ff[0][c][bcft_pkg::CW-1], p_ff[0][c]};
         job_geom.b[c]     = {p_cur[c][bcft_pkg::CW-1], p_cur[c]}
                           - {p_ff[0][c][bcft_pkg::CW-1], p_ff[0][c]};
         job_geom.nv[0][c] = nv_ff[0][c];
         job_geom.nv[1][c] = nv_ff[1][c];
         job_geom.nv[2][c] = nv_cur[c];
      end
      job_ids = {id_cur, id_ff[1], id_ff[0]};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         slot_ff <= 2'd0;
      end else begin
         slot_ff <= slot_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept && !third) begin
         for (int c = 0; c < bcft_pkg::AXES; c++) begin
            p_ff[slot_ff[0]][c]  <= p_cur[c];
            nv_ff[slot_ff[0]][c] <= nv_cur[c];
         end
         id_ff[slot_ff[0]] <= id_cur;
      end
   end

endmodule

// ===== src/bcft_divu.sv =====
// restoring divider, one quotient bit per cycle
module bcft_divu (
   input  logic                               clock,
   input  logic                               reset,
   input  bcft_pkg::div_req_type              req,
   input  logic [bcft_pkg::DIV_REM_W-1:0]     rem_init,
   input  logic [bcft_pkg::QW-1:0]            low,
   input  logic [bcft_pkg::DIV_REM_W-1:0]     divisor,
   output logic                               done,
   output logic [bcft_pkg::QW-1:0]            quot
);

   localparam int RW = bcft_pkg::DIV_REM_W;
   localparam int QW = bcft_pkg::QW;
   localparam int SW = bcft_pkg::STEP_W;

   logic [RW-1:0] rem_ff, rem_in;
   logic [QW-1:0] low_ff, low_in;
   logic [QW-1:0] quot_ff, quot_in;
   logic [RW-1:0] div_ff, div_in;
   logic [SW-1:0] cnt_ff, cnt_in;
   logic          busy_ff, busy_in;
   logic          done_ff, done_in;
   logic [RW:0]   trial;
   logic          ge;

   always_comb begin
      trial   = {rem_ff, low_ff[QW-1]};
      ge      = (trial >= {1'b0, div_ff});
      rem_in  = rem_ff;
      low_in  = low_ff;
      quot_in = quot_ff;
      div_in  = div_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (req.start) begin
         rem_in  = rem_init;
         low_in  = low;
         quot_in = '0;
         div_in  = divisor;
         cnt_in  = req.steps;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         rem_in  = ge ? RW'(trial - {1'b0, div_ff}) : trial[RW-1:0];
         low_in  = {low_ff[QW-2:0], 1'b0};
         quot_in = {quot_ff[QW-2:0], ge};
         cnt_in  = cnt_ff - SW'(1);
         if (cnt_ff == SW'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
      done = done_ff;
      quot = quot_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff  <= rem_in;
      low_ff  <= low_in;
      quot_ff <= quot_in;
      div_ff  <= div_in;
      cnt_ff  <= cnt_in;
   end

endmodule

// ===== src/bcft_isqrt.sv =====
// integer square root, one result bit per cycle
module bcft_isqrt (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   input  logic [bcft_pkg::RADW-1:0]      radicand,
   output logic                           done,
   output logic [bcft_pkg::ROOTW-1:0]     root
);

   localparam int XW = bcft_pkg::RADW;
   localparam int RW = bcft_pkg::ROOTW;
   localparam int MW = bcft_pkg::SQRT_REMW;

   logic [XW-1:0] x_ff, x_in;
   logic [MW-1:0] rem_ff, rem_in;
   logic [RW-1:0] root_ff, root_in;
   logic [5:0]    cnt_ff, cnt_in;
   logic          busy_ff, busy_in;
   logic          done_ff, done_in;
   logic [MW-1:0] part;
   logic [MW-1:0] trial;
   logic          ge;

   always_comb begin
      part    = {rem_ff[MW-3:0], x_ff[XW-1:XW-2]};
      trial   = MW'({root_ff, 2'b01});
      ge      = (part >= trial);
      x_in    = x_ff;
      rem_in  = rem_ff;
      root_in = root_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         x_in    = radicand;
         rem_in  = '0;
         root_in = '0;
         cnt_in  = 6'(RW);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         x_in    = {x_ff[XW-3:0], 2'b00};
         rem_in  = ge ? part - trial : part;
         root_in = {root_ff[RW-2:0], ge};
         cnt_in  = cnt_ff - 6'd1;
         if (cnt_ff == 6'd1) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
      done = done_ff;
      root = root_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      x_ff    <= x_in;
      rem_ff  <= rem_in;
      root_ff <= root_in;
      cnt_ff  <= cnt_in;
   end

endmodule

// ===== src/bcft_back.sv =====
// triangle solver: orientation, circle center, ball offset, result register
module bcft_back #(
   parameter int ID_WIDTH = 16
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   job_valid,
   output logic                   job_pop,
   input  bcft_pkg::geom_type     job_geom,
   input  logic [3*ID_WIDTH-1:0]  job_ids,
   input  logic [31:0]            ball_radius,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output logic signed [31:0]     rsp_center_x,
   output logic signed [31:0]     rsp_center_y,
   output logic signed [31:0]     rsp_center_z,
   output logic                   rsp_found,
   output logic [15:0]            rsp_order_first,
   output logic [15:0]            rsp_order_second,
   output logic [15:0]            rsp_order_third
);

   localparam int AXES  = bcft_pkg::AXES;
   localparam int CW    = bcft_pkg::CW;
   localparam int EW    = bcft_pkg::EW;
   localparam int NW    = bcft_pkg::NW;
   localparam int MW    = bcft_pkg::MW;
   localparam int EXPW  = bcft_pkg::EXPW;
   localparam int NCW   = bcft_pkg::NCW;
   localparam int AAW   = bcft_pkg::AAW;
   localparam int ABW   = bcft_pkg::ABW;
   localparam int DW    = bcft_pkg::DW;
   localparam int SW    = bcft_pkg::SW;
   localparam int NUMW  = bcft_pkg::NUMW;
   localparam int MAGW  = bcft_pkg::MAGW;
   localparam int BIGW  = bcft_pkg::BIGW;
   localparam int QW    = bcft_pkg::QW;
   localparam int UW    = bcft_pkg::UW;
   localparam int RW    = bcft_pkg::DIV_REM_W;
   localparam int RADW  = bcft_pkg::RADW;
   localparam int ROOTW = bcft_pkg::ROOTW;
   localparam int SHW   = bcft_pkg::SHIFTW;
   localparam int AXW   = bcft_pkg::AXISW;
   localparam int SUMW  = bcft_pkg::SUMW;
   localparam int DOTW  = 43;
   localparam int HIW   = BIGW - QW;
   localparam int XSW   = NCW + 31;

   bcft_pkg::back_state_type state_ff, state_in;

   logic [CW-1:0]           p0_ff  [AXES], p0_in  [AXES];
   logic [EW-1:0]           a_ff   [AXES], a_in   [AXES];
   logic [EW-1:0]           b_ff   [AXES], b_in   [AXES];
   logic [NW-1:0]           nv_ff  [AXES][AXES], nv_in [AXES][AXES];
   logic [ID_WIDTH-1:0]     id_ff  [AXES], id_in  [AXES];
   logic [EW-1:0]           or_ff, or_in;
   logic [EXPW-1:0]         e_ff, e_in;
   logic signed [NCW-1:0]   n_ff   [AXES], n_in   [AXES];
   logic [AAW-1:0]          aa_ff, aa_in, bb_ff, bb_in;
   logic signed [ABW-1:0]   ab_ff, ab_in;
   logic [DW-1:0]           d_ff, d_in;
   logic                    flip_ff, flip_in;
   logic signed [SW-1:0]    sn_ff, sn_in, tn_ff, tn_in;
   logic [AXW-1:0]          c_ff, c_in;
   logic                    neg_ff, neg_in;
   logic [MAGW-1:0]         mag_ff, mag_in;
   logic signed [UW-1:0]    u_ff   [AXES], u_in   [AXES];
   logic                    fits_ff, fits_in;
   logic [RADW-1:0]         r2_ff, r2_in, rb2_ff, rb2_in;
   logic [ROOTW-1:0]        h_ff, h_in, s_ff, s_in;
   logic [RADW-1:0]         dn_ff, dn_in;
   logic [SHW-1:0]          m_ff, m_in;
   logic [RADW-1:0]         prod_ff, prod_in;
   logic [CW-1:0]           ctr_ff [AXES], ctr_in [AXES];
   logic                    found_ff, found_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic [CW-1:0]           rsp_ctr_ff [AXES], rsp_ctr_in [AXES];
   logic                    rsp_found_ff, rsp_found_in;
   logic [15:0]             rsp_ord_ff [AXES], rsp_ord_in [AXES];

   bcft_pkg::div_req_type   div_req;
   logic [RW-1:0]           div_rem_init;
   logic [QW-1:0]           div_low;
   logic [RW-1:0]           div_divisor;
   logic                    div_done;
   logic [QW-1:0]           div_quot;
   logic                    sqrt_start;
   logic [RADW-1:0]         sqrt_rad;
   logic                    sqrt_done;
   logic [ROOTW-1:0]        sqrt_root;

   bcft_divu u_divu (
      .clock    (clock),
      .reset    (reset),
      .req      (div_req),
      .rem_init (div_rem_init),
      .low      (div_low),
      .divisor  (div_divisor),
      .done     (div_done),
      .quot     (div_quot)
   );

   bcft_isqrt u_isqrt (
      .clock    (clock),
      .reset    (reset),
      .start    (sqrt_start),
      .radicand (sqrt_rad),
      .done     (sqrt_done),
      .root     (sqrt_root)
   );

   always_comb begin
      logic [EW-1:0]          amag [AXES];
      logic [EW-1:0]          bmag [AXES];
      logic [EW-1:0]          or_all;
      logic signed [NCW-1:0]  ae [AXES];
      logic signed [NCW-1:0]  be [AXES];
      logic signed [DW-1:0]   nw [AXES];
      logic signed [DOTW-1:0] dot [AXES];
      logic signed [DOTW-1:0] nd [AXES];
      logic signed [ABW:0]    dif_a, dif_b;
      logic signed [NUMW-1:0] num;
      logic [BIGW-1:0]        big;
      logic [RW-1:0]          v;
      logic [QW-1:0]          q;
      logic [QW-1:0]          umag;
      logic [RADW-1:0]        m2;
      logic [RADW:0]          acc;
      logic [NCW-1:0]         nabs;
      logic [XSW-1:0]         xs;
      logic signed [SUMW-1:0] sum;
      logic signed [SUMW-1:0] offs;
      logic                   neg_off;

      state_in     = state_ff;
      p0_in        = p0_ff;
      a_in         = a_ff;
      b_in         = b_ff;
      nv_in        = nv_ff;
      id_in        = id_ff;
      or_in        = or_ff;
      e_in         = e_ff;
      n_in         = n_ff;
      aa_in        = aa_ff;
      bb_in        = bb_ff;
      ab_in        = ab_ff;
      d_in         = d_ff;
      flip_in      = flip_ff;
      sn_in        = sn_ff;
      tn_in        = tn_ff;
      c_in         = c_ff;
      neg_in       = neg_ff;
      mag_in       = mag_ff;
      u_in         = u_ff;
      fits_in      = fits_ff;
      r2_in        = r2_ff;
      rb2_in       = rb2_ff;
      h_in         = h_ff;
      s_in         = s_ff;
      dn_in        = dn_ff;
      m_in         = m_ff;
      prod_in      = prod_ff;
      ctr_in       = ctr_ff;
      found_in     = found_ff;
      rsp_ctr_in   = rsp_ctr_ff;
      rsp_found_in = rsp_found_ff;
      rsp_ord_in   = rsp_ord_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      job_pop      = 1'b0;
      div_req.start = 1'b0;
      div_req.steps = bcft_pkg::STEP_W'(bcft_pkg::U_STEPS);
      div_rem_init = '0;
      div_low      = '0;
      div_divisor  = {d_ff, 1'b0};
      sqrt_start   = 1'b0;
      sqrt_rad     = rb2_ff - r2_ff;

      or_all = '0;
      for (int c = 0; c < AXES; c++) begin
         amag[c] = job_geom.a[c][EW-1] ? -job_geom.a[c] : job_geom.a[c];
         bmag[c] = job_geom.b[c][EW-1] ? -job_geom.b[c] : job_geom.b[c];
         or_all  = or_all | amag[c] | bmag[c];
         ae[c]   = NCW'($signed(a_ff[c][MW-1:0]));
         be[c]   = NCW'($signed(b_ff[c][MW-1:0]));
         nw[c]   = DW'(n_ff[c]);
         nd[c]   = DOTW'(n_ff[c]);
      end
      for (int k = 0; k < AXES; k++) begin
         dot[k] = DOTW'($signed(nv_ff[k][0])) * nd[0]
                + DOTW'($signed(nv_ff[k][1])) * nd[1]
                + DOTW'($signed(nv_ff[k][2])) * nd[2];
      end
      dif_a   = (ABW+1)'($signed({1'b0, aa_ff})) - (ABW+1)'(ab_ff);
      dif_b   = (ABW+1)'($signed({1'b0, bb_ff})) - (ABW+1)'(ab_ff);
      num     = NUMW'(sn_ff) * NUMW'(ae[c_ff]) + NUMW'(tn_ff) * NUMW'(be[c_ff]);
      big     = BIGW'(mag_ff) << e_ff;
      v       = {d_ff, 1'b0};
      q       = (div_quot > bcft_pkg::QUOT_CAP) ? bcft_pkg::QUOT_CAP : div_quot;
      umag    = QW'(u_ff[c_ff][UW-1] ? -u_ff[c_ff] : u_ff[c_ff]);
      m2      = RADW'(umag[31:0]) * RADW'(umag[31:0]);
      acc     = {1'b0, r2_ff} + {1'b0, m2};
      nabs    = n_ff[c_ff][NCW-1] ? NCW'(-n_ff[c_ff]) : NCW'(n_ff[c_ff]);
      xs      = XSW'(nabs) << m_ff;
      neg_off = n_ff[c_ff][NCW-1] != flip_ff;
      offs    = $signed(SUMW'(div_quot[ROOTW-1:0]));
      sum     = SUMW'($signed(p0_ff[c_ff])) + SUMW'(u_ff[c_ff])
              + (neg_off ? -offs : offs);

      case (state_ff)
         bcft_pkg::ST_IDLE: begin
            if (job_valid) begin
               job_pop = 1'b1;
               for (int c = 0; c < AXES; c++) begin
                  p0_in[c]  = job_geom.p0[c];
                  a_in[c]   = job_geom.a[c];
                  b_in[c]   = job_geom.b[c];
                  ctr_in[c] = '0;
                  id_in[c]  = job_ids[c*ID_WIDTH +: ID_WIDTH];
                  for (int k = 0; k < AXES; k++) begin
                     nv_in[k][c] = job_geom.nv[k][c];
                  end
               end
               or_in    = or_all;
               e_in     = '0;
               flip_in  = 1'b0;
               found_in = 1'b0;
               state_in = bcft_pkg::ST_NORM;
            end
         end
         bcft_pkg::ST_NORM: begin
            // arithmetic shift by one per cycle is the floor shift
            if (or_ff > EW'(bcft_pkg::MANT_MAX)) begin
               or_in = or_ff >> 1;
               e_in  = e_ff + EXPW'(1);
               for (int c = 0; c < AXES; c++) begin
                  a_in[c] = {a_ff[c][EW-1], a_ff[c][EW-1:1]};
                  b_in[c] = {b_ff[c][EW-1], b_ff[c][EW-1:1]};
               end
            end else begin
               state_in = bcft_pkg::ST_CROSS;
            end
         end
         bcft_pkg::ST_CROSS: begin
            n_in[0]  = ae[1] * be[2] - ae[2] * be[1];
            n_in[1]  = ae[2] * be[0] - ae[0] * be[2];
            n_in[2]  = ae[0] * be[1] - ae[1] * be[0];
            state_in = bcft_pkg::ST_DOTS;
         end
         bcft_pkg::ST_DOTS: begin
            aa_in    = AAW'(ae[0] * ae[0] + ae[1] * ae[1] + ae[2] * ae[2]);
            bb_in    = AAW'(be[0] * be[0] + be[1] * be[1] + be[2] * be[2]);
            ab_in    = ae[0] * be[0] + ae[1] * be[1] + ae[2] * be[2];
            state_in = bcft_pkg::ST_DSQ;
         end
         bcft_pkg::ST_DSQ: begin
            d_in     = DW'(nw[0] * nw[0] + nw[1] * nw[1] + nw[2] * nw[2]);
            state_in = bcft_pkg::ST_ORIENT;
         end
         bcft_pkg::ST_ORIENT: begin
            if (d_ff == '0) begin
               state_in = bcft_pkg::ST_OUT;
            end else begin
               // two of three normals against the face normal
               flip_in  = (dot[0][DOTW-1] && dot[1][DOTW-1])
                       || (dot[0][DOTW-1] && dot[2][DOTW-1])
                       || (dot[1][DOTW-1] && dot[2][DOTW-1]);
               state_in = bcft_pkg::ST_SNTN;
            end
         end
         bcft_pkg::ST_SNTN: begin
            sn_in    = $signed(SW'(bb_ff)) * SW'(dif_a);
            tn_in    = $signed(SW'(aa_ff)) * SW'(dif_b);
            c_in     = '0;
            r2_in    = '0;
            fits_in  = 1'b1;
            state_in = bcft_pkg::ST_UNUM;
         end
         bcft_pkg::ST_UNUM: begin
            neg_in   = num[NUMW-1];
            mag_in   = MAGW'(num[NUMW-1] ? -num : num);
            state_in = bcft_pkg::ST_USTART;
         end
         bcft_pkg::ST_USTART: begin
            // a quotient of 2^41 or more is capped without dividing
            if (RW'(big[BIGW-1:QW]) >= v) begin
               u_in[c_ff] = neg_ff ? -UW'(bcft_pkg::QUOT_CAP) : UW'(bcft_pkg::QUOT_CAP);
               state_in   = bcft_pkg::ST_UACC;
            end else begin
               div_req.start = 1'b1;
               div_rem_init  = RW'(big[BIGW-1:QW]);
               div_low       = big[QW-1:0];
               state_in      = bcft_pkg::ST_UWAIT;
            end
         end
         bcft_pkg::ST_UWAIT: begin
            if (div_done) begin
               u_in[c_ff] = neg_ff ? -UW'(q) : UW'(q);
               state_in   = bcft_pkg::ST_UACC;
            end
         end
         bcft_pkg::ST_UACC: begin
            if (umag[QW-1:32] != '0) begin
               fits_in = 1'b0;
            end else begin
               r2_in = acc[RADW] ? '1 : acc[RADW-1:0];
            end
            if (c_ff == AXW'(AXES - 1)) begin
               state_in = bcft_pkg::ST_RB;
            end else begin
               c_in     = c_ff + AXW'(1);
               state_in = bcft_pkg::ST_UNUM;
            end
         end
         bcft_pkg::ST_RB: begin
            rb2_in   = RADW'(ball_radius) * RADW'(ball_radius);
            state_in = bcft_pkg::ST_RCMP;
         end
         bcft_pkg::ST_RCMP: begin
            if (fits_ff && (rb2_ff > r2_ff)) begin
               sqrt_start = 1'b1;
               state_in   = bcft_pkg::ST_HWAIT;
            end else begin
               state_in = bcft_pkg::ST_OUT;
            end
         end
         bcft_pkg::ST_HWAIT: begin
            if (sqrt_done) begin
               h_in     = sqrt_root;
               dn_in    = RADW'(d_ff);
               m_in     = '0;
               state_in = bcft_pkg::ST_DNORM;
            end
         end
         bcft_pkg::ST_DNORM: begin
            // even normalizing shift, two bits a cycle
            sqrt_rad = dn_ff;
            if (dn_ff[RADW-1:RADW-4] == 4'd0) begin
               dn_in = {dn_ff[RADW-3:0], 2'b00};
               m_in  = m_ff + SHW'(1);
            end else begin
               sqrt_start = 1'b1;
               state_in   = bcft_pkg::ST_SWAIT;
            end
         end
         bcft_pkg::ST_SWAIT: begin
            if (sqrt_done) begin
               s_in     = sqrt_root;
               c_in     = '0;
               state_in = bcft_pkg::ST_OMUL;
            end
         end
         bcft_pkg::ST_OMUL: begin
            prod_in  = RADW'(h_ff) * RADW'(xs[ROOTW-1:0]);
            state_in = bcft_pkg::ST_OSTART;
         end
         bcft_pkg::ST_OSTART: begin
            div_req.start = 1'b1;
            div_req.steps = bcft_pkg::STEP_W'(bcft_pkg::O_STEPS);
            div_rem_init  = RW'(prod_ff[RADW-1:ROOTW]);
            div_low       = {prod_ff[ROOTW-1:0], {(QW-ROOTW){1'b0}}};
            div_divisor   = RW'(s_ff);
            state_in      = bcft_pkg::ST_OWAIT;
         end
         bcft_pkg::ST_OWAIT: begin
            if (div_done) begin
               if (sum[SUMW-1:CW-1] != '0 && sum[SUMW-1:CW-1] != '1) begin
                  ctr_in[c_ff] = sum[SUMW-1] ? 32'h8000_0000 : 32'h7FFF_FFFF;
               end else begin
                  ctr_in[c_ff] = sum[CW-1:0];
               end
               if (c_ff == AXW'(AXES - 1)) begin
                  found_in = 1'b1;
                  state_in = bcft_pkg::ST_OUT;
               end else begin
                  c_in     = c_ff + AXW'(1);
                  state_in = bcft_pkg::ST_OMUL;
               end
            end
         end
         bcft_pkg::ST_OUT: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in  = 1'b1;
               rsp_ctr_in    = ctr_ff;
               rsp_found_in  = found_ff;
               rsp_ord_in[0] = 16'(flip_ff ? id_ff[1] : id_ff[0]);
               rsp_ord_in[1] = 16'(flip_ff ? id_ff[0] : id_ff[1]);
               rsp_ord_in[2] = 16'(id_ff[2]);
               state_in      = bcft_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = bcft_pkg::ST_IDLE;
         end
      endcase

      rsp_valid        = rsp_valid_ff;
      rsp_center_x     = rsp_ctr_ff[0];
      rsp_center_y     = rsp_ctr_ff[1];
      rsp_center_z     = rsp_ctr_ff[2];
      rsp_found        = rsp_found_ff;
      rsp_order_first  = rsp_ord_ff[0];
      rsp_order_second = rsp_ord_ff[1];
      rsp_order_third  = rsp_ord_ff[2];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= bcft_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      p0_ff        <= p0_in;
      a_ff         <= a_in;
      b_ff         <= b_in;
      nv_ff        <= nv_in;
      id_ff        <= id_in;
      or_ff        <= or_in;
      e_ff         <= e_in;
      n_ff         <= n_in;
      aa_ff        <= aa_in;
      bb_ff        <= bb_in;
      ab_ff        <= ab_in;
      d_ff         <= d_in;
      flip_ff      <= flip_in;
      sn_ff        <= sn_in;
      tn_ff        <= tn_in;
      c_ff         <= c_in;
      neg_ff       <= neg_in;
      mag_ff       <= mag_in;
      u_ff         <= u_in;
      fits_ff      <= fits_in;
      r2_ff        <= r2_in;
      rb2_ff       <= rb2_in;
      h_ff         <= h_in;
      s_ff         <= s_in;
      dn_ff        <= dn_in;
      m_ff         <= m_in;
      prod_ff      <= prod_in;
      ctr_ff       <= ctr_in;
      found_ff     <= found_in;
      rsp_ctr_ff   <= rsp_ctr_in;
      rsp_found_ff <= rsp_found_in;
      rsp_ord_ff   <= rsp_ord_in;
   end

endmodule

// ===== src/ball_center_from_triangle_top.sv =====
// ball center from triangle: top level with ball radius register
//
// Points enter on the req_ channel, one per beat; every third beat closes a
// triangle with the two points held before it. Each triangle gives one beat
// on the rsp_ channel: the ball center, a found flag and the point ids in
// the order after the orientation test. The first two points give nothing.
// The csr_ channel writes the ball radius (Q16.16); it is always ready and
// should be written only while no triangle is in flight.
// The solver handles one triangle at a time with its shared one-bit-a-cycle
// divider and square root unit: it first normalizes by a block exponent; a
// degenerate triangle then ends, and otherwise three divisions give the
// circle center (large quotients are capped), after which a ball that
// does not fit ends; a found center takes two square roots around a
// normalizing shift, then three divisions for the ball offset.
// A two-entry job queue lets points keep arriving while a triangle is solved.
// Reset empties the point slots and the queue and sets the radius to one.
// While rsp_ready is low the result holds and the solver waits after its
// next triangle; the collector then stalls once the queue is full.
module ball_center_from_triangle_top #(
   parameter int ID_WIDTH  = 16,
   parameter int FRAC_BITS = 16
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic signed [31:0] req_point_x,
   input  logic signed [31:0] req_point_y,
   input  logic signed [31:0] req_point_z,
   input  logic signed [15:0] req_normal_x,
   input  logic signed [15:0] req_normal_y,
   input  logic signed [15:0] req_normal_z,
   input  logic [15:0]        req_point_id,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic signed [31:0] rsp_center_x,
   output logic signed [31:0] rsp_center_y,
   output logic signed [31:0] rsp_center_z,
   output logic               rsp_found,
   output logic [15:0]        rsp_order_first,
   output logic [15:0]        rsp_order_second,
   output logic [15:0]        rsp_order_third,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [31:0]        csr_data
);

   localparam int JOB_W = $bits(bcft_pkg::geom_type) + 3 * ID_WIDTH;

   logic [31:0]              ball_radius_ff, ball_radius_in;
   logic                     job_push;
   bcft_pkg::geom_type       push_geom;
   logic [3*ID_WIDTH-1:0]    push_ids;
   logic                     job_full;
   logic                     job_pop;
   logic                     job_valid;
   logic [JOB_W-1:0]         pop_data;
   bcft_pkg::geom_type       pop_geom;
   logic [3*ID_WIDTH-1:0]    pop_ids;

   always_comb begin
      csr_ready      = 1'b1;
      ball_radius_in = (csr_valid && csr_ready) ? csr_data : ball_radius_ff;
      pop_geom       = pop_data[$bits(bcft_pkg::geom_type)-1:0];
      pop_ids        = pop_data[JOB_W-1:$bits(bcft_pkg::geom_type)];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ball_radius_ff <= 32'(64'd1 << FRAC_BITS);
      end else begin
         ball_radius_ff <= ball_radius_in;
      end
   end

   bcft_front #(
      .ID_WIDTH (ID_WIDTH)
   ) u_front (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_ready    (req_ready),
      .req_point_x  (req_point_x),
      .req_point_y  (req_point_y),
      .req_point_z  (req_point_z),
      .req_normal_x (req_normal_x),
      .req_normal_y (req_normal_y),
      .req_normal_z (req_normal_z),
      .req_point_id (req_point_id),
      .job_push     (job_push),
      .job_geom     (push_geom),
      .job_ids      (push_ids),
      .job_full     (job_full)
   );

   bcft_fifo #(
      .WIDTH (JOB_W)
   ) u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (job_push),
      .push_data ({push_ids, push_geom}),
      .full      (job_full),
      .pop       (job_pop),
      .not_empty (job_valid),
      .pop_data  (pop_data)
   );

   bcft_back #(
      .ID_WIDTH (ID_WIDTH)
   ) u_back (
      .clock            (clock),
      .reset            (reset),
      .job_valid        (job_valid),
      .job_pop          (job_pop),
      .job_geom         (pop_geom),
      .job_ids          (pop_ids),
      .ball_radius      (ball_radius_ff),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_center_x     (rsp_center_x),
      .rsp_center_y     (rsp_center_y),
      .rsp_center_z     (rsp_center_z),
      .rsp_found        (rsp_found),
      .rsp_order_first  (rsp_order_first),
      .rsp_order_second (rsp_order_second),
      .rsp_order_third  (rsp_order_third)
   );

endmodule
